### hw/rtl/ulf_pkg.sv
// constants, codes and helper functions for the uart line framer
// no dependencies
`timescale 1ns / 1ps

package ulf_pkg;

  localparam int ModeW = 2;
  localparam int KindW = 2;
  localparam int ByteW = 8;
  localparam int FillW = 6;

  localparam logic [ModeW-1:0] MODE_BYTE = 2'd0;
  localparam logic [ModeW-1:0] MODE_IDLE = 2'd1;
  localparam logic [ModeW-1:0] MODE_TAKE = 2'd2;

  localparam logic [KindW-1:0] KIND_STATUS = 2'd0;
  localparam logic [KindW-1:0] KIND_LINE   = 2'd1;
  localparam logic [KindW-1:0] KIND_NONE   = 2'd2;

  localparam logic [ByteW-1:0] CH_LF  = 8'h0a;
  localparam logic [ByteW-1:0] CH_CR  = 8'h0d;
  localparam logic [ByteW-1:0] CH_NUL = 8'h00;

  function automatic logic is_crlf(input logic [ByteW-1:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_trail(input logic [ByteW-1:0] c);
    return is_crlf(c) || (c == CH_NUL);
  endfunction

endpackage

### hw/rtl/ulf_if.sv
// request and result channels of the uart line framer
// depends on ulf_pkg
`timescale 1ns / 1ps

interface ulf_req_if import ulf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface ulf_res_if import ulf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] line_byte;
  logic             last;
  logic             line_ready;
  logic [FillW-1:0] fill_count;

  modport source (output valid, output kind, output line_byte, output last,
                  output line_ready, output fill_count, input ready);
  modport sink   (input valid, input kind, input line_byte, input last,
                  input line_ready, input fill_count, output ready);
endinterface

### hw/rtl/uart_line_framer_trim.sv
// byte or idle request: result registered after acceptance; next taken once result slot free
// take request: trim bytes from the back, then from the front, then line bytes, each read
// through the one synchronous read port of the line store, one result register after it
// reset clears fill count, line flag, sequencer and result valid at once; no clearing pass,
// store contents stay undefined until written
// depends on ulf_pkg and ulf_if
`timescale 1ns / 1ps

module uart_line_framer_trim import ulf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ulf_req_if.sink   req_i,
  ulf_res_if.source res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] CAP = AW'(DEPTH - 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_BACK_RD   = 3'd1;
  localparam logic [2:0] S_BACK_CHK  = 3'd2;
  localparam logic [2:0] S_FRONT_RD  = 3'd3;
  localparam logic [2:0] S_FRONT_CHK = 3'd4;
  localparam logic [2:0] S_EMIT_RD   = 3'd5;
  localparam logic [2:0] S_EMIT_OUT  = 3'd6;
  localparam logic [2:0] S_EMPTY     = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    fill_q, fill_d;
  logic             done_q, done_d;
  logic [AW-1:0]    len_q, len_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [ByteW-1:0] cur_q, cur_d;
  logic             end_q, end_d;

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rdata_q;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr;

  logic             ovalid_q;
  logic [KindW-1:0] okind_q;
  logic [ByteW-1:0] obyte_q;
  logic             olast_q;
  logic             oready_q;
  logic [FillW-1:0] ofill_q;

  logic             slot_free, accept, push, push_last;
  logic [KindW-1:0] push_kind;
  logic [ByteW-1:0] push_byte;

  assign slot_free   = !ovalid_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    done_d    = done_q;
    len_d     = len_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    end_d     = end_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    push      = 1'b0;
    push_kind = KIND_STATUS;
    push_byte = CH_NUL;
    push_last = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.mode)
            MODE_BYTE: begin
              if (!done_q && (fill_q < CAP)) begin
                wr_en  = 1'b1;
                fill_d = fill_q + AW'(1);
                if (req_i.rx_byte == CH_LF) done_d = 1'b1;
              end
              push = 1'b1;
            end
            MODE_TAKE: begin
              if (!done_q) begin
                push      = 1'b1;
                push_kind = KIND_NONE;
              end else begin
                len_d   = fill_q;
                fill_d  = '0;
                done_d  = 1'b0;
                state_d = S_BACK_RD;
              end
            end
            default: begin
              if ((req_i.mode == MODE_IDLE) && (fill_q != '0)) done_d = 1'b1;
              push = 1'b1;
            end
          endcase
        end
      end
      S_BACK_RD: begin
        if (len_q == '0) begin
          state_d = S_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = len_q - AW'(1);
          state_d = S_BACK_CHK;
        end
      end
      S_BACK_CHK: begin
        if (is_trail(rdata_q)) begin
          len_d   = len_q - AW'(1);
          state_d = S_BACK_RD;
        end else begin
          idx_d   = '0;
          state_d = S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        if (idx_q == len_q) begin
          state_d = S_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q;
          state_d = S_FRONT_CHK;
        end
      end
      S_FRONT_CHK: begin
        if (is_crlf(rdata_q)) begin
          idx_d   = idx_q + AW'(1);
          state_d = S_FRONT_RD;
        end else if (rdata_q == CH_NUL) begin
          state_d = S_EMPTY;
        end else begin
          cur_d   = rdata_q;
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        end_d   = ({1'b0, idx_q} + (AW+1)'(1)) == {1'b0, len_q};
        rd_en   = !end_d;
        rd_addr = idx_q + AW'(1);
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (slot_free) begin
          push      = 1'b1;
          push_kind = KIND_LINE;
          push_byte = cur_q;
          push_last = end_q || (rdata_q == CH_NUL);
          if (push_last) begin
            state_d = S_IDLE;
          end else begin
            cur_d   = rdata_q;
            idx_d   = idx_q + AW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          push      = 1'b1;
          push_kind = KIND_NONE;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[fill_q] <= req_i.rx_byte;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      if (push) begin
        ovalid_q <= 1'b1;
      end else if (res_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    idx_q <= idx_d;
    cur_q <= cur_d;
    end_q <= end_d;
    if (push) begin
      okind_q  <= push_kind;
      obyte_q  <= push_byte;
      olast_q  <= push_last;
      oready_q <= done_d;
      ofill_q  <= FillW'(fill_d);
    end
  end

  assign res_o.valid      = ovalid_q;
  assign res_o.kind       = okind_q;
  assign res_o.line_byte  = obyte_q;
  assign res_o.last       = olast_q;
  assign res_o.line_ready = oready_q;
  assign res_o.fill_count = ofill_q;

endmodule

### hw/rtl/ulf_checker.sv
// port level checks on the uart line framer results
// depends on ulf_pkg; bound to uart_line_framer_trim
`timescale 1ns / 1ps

module ulf_checker import ulf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [KindW-1:0] res_kind_i,
  input logic [ByteW-1:0] res_byte_i,
  input logic             res_last_i,
  input logic             res_line_ready_i,
  input logic [FillW-1:0] res_fill_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i)
      && $stable(res_byte_i) && $stable(res_last_i))
    else $error("stalled result changed");

  // status and no-line results stand alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i != KIND_LINE) |-> res_last_i && (res_byte_i == CH_NUL))
    else $error("non-line result not single");

  // line bytes come after the store was emptied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_LINE) |-> !res_line_ready_i && (res_fill_i == '0)
      && (res_byte_i != CH_NUL))
    else $error("line byte with store not empty");

  // a complete line is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_line_ready_i |-> res_fill_i != '0)
    else $error("line complete on empty store");

endmodule

bind uart_line_framer_trim ulf_checker u_ulf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_kind_i       (res_o.kind),
  .res_byte_i       (res_o.line_byte),
  .res_last_i       (res_o.last),
  .res_line_ready_i (res_o.line_ready),
  .res_fill_i       (res_o.fill_count)
);

### tb/ulf_line_checker.sv
// result checker for uart_line_framer_trim: predicts the results of every accepted request
// and compares each accepted result with the oldest prediction, field by field
// depends on ulf_pkg and ulf_if
`timescale 1ns / 1ps

module ulf_line_checker import ulf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ulf_req_if   req,
  ulf_res_if   res,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] line_byte;
    logic             last;
    logic             line_ready;
    logic [FillW-1:0] fill_count;
  } line_result_t;

  logic [ByteW-1:0] held_bytes [DEPTH];
  int               held_len;
  logic             line_flag;
  line_result_t     line_results_q [$];
  int               result_idx;

  task automatic push_line_result(input logic [KindW-1:0] kind, input logic [ByteW-1:0] data,
                                  input logic last);
    line_result_t r;
    r.kind       = kind;
    r.line_byte  = data;
    r.last       = last;
    r.line_ready = line_flag;
    r.fill_count = FillW'(held_len);
    line_results_q.push_back(r);
  endtask

  task automatic predict_request(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] data);
    int len;
    int head;
    int stop;
    case (mode)
      MODE_BYTE: begin
        if (!line_flag && held_len < DEPTH - 1) begin
          held_bytes[held_len] = data;
          held_len++;
          if (data == CH_LF) line_flag = 1'b1;
        end
        push_line_result(KIND_STATUS, '0, 1'b1);
      end
      MODE_TAKE: begin
        if (!line_flag) begin
          push_line_result(KIND_NONE, '0, 1'b1);
        end else begin
          len       = held_len;
          held_len  = 0;
          line_flag = 1'b0;
          // drop trailing cr, lf and nul, then leading cr and lf
          while (len > 0 && (held_bytes[len-1] == CH_CR || held_bytes[len-1] == CH_LF ||
                             held_bytes[len-1] == CH_NUL))
            len--;
          head = 0;
          while (head < len && (held_bytes[head] == CH_CR || held_bytes[head] == CH_LF))
            head++;
          stop = head;
          while (stop < len && held_bytes[stop] != CH_NUL) stop++;
          if (stop == head) begin
            push_line_result(KIND_NONE, '0, 1'b1);
          end else begin
            for (int i = head; i < stop; i++)
              push_line_result(KIND_LINE, held_bytes[i], i + 1 == stop);
          end
        end
      end
      default: begin
        if (mode == MODE_IDLE && held_len > 0) line_flag = 1'b1;
        push_line_result(KIND_STATUS, '0, 1'b1);
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_line_result(input line_result_t got);
    line_result_t want;
    if (line_results_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending", result_idx));
    end else begin
      want = line_results_q.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("result %0d kind %0d, want %0d", result_idx, got.kind,
                                  want.kind));
      if (got.line_byte != want.line_byte)
        report_mismatch($sformatf("result %0d line_byte %02h, want %02h", result_idx,
                                  got.line_byte, want.line_byte));
      if (got.last != want.last)
        report_mismatch($sformatf("result %0d last %0d, want %0d", result_idx, got.last,
                                  want.last));
      if (got.line_ready != want.line_ready)
        report_mismatch($sformatf("result %0d line_ready %0d, want %0d", result_idx,
                                  got.line_ready, want.line_ready));
      if (got.fill_count != want.fill_count)
        report_mismatch($sformatf("result %0d fill_count %0d, want %0d", result_idx,
                                  got.fill_count, want.fill_count));
    end
    result_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_len      = 0;
      line_flag     = 1'b0;
      line_results_q.delete();
      result_idx    = 0;
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (req.valid && req.ready) predict_request(req.mode, req.rx_byte);
      if (res.valid && res.ready)
        check_line_result(line_result_t'{res.kind, res.line_byte, res.last, res.line_ready,
                                         res.fill_count});
      pending_count = line_results_q.size();
    end
  end

endmodule

### tb/tb_uart_line_framer_trim.sv
// testbench top for uart_line_framer_trim: drives directed and random requests with random
// gaps and result stalls, and gives the verdict from the count of ulf_line_checker
// depends on ulf_pkg, ulf_if, uart_line_framer_trim and ulf_line_checker
`timescale 1ns / 1ps

module tb_uart_line_framer_trim import ulf_pkg::*;;

  localparam int DEPTH       = 64;
  localparam int RandomItems = 480;
  localparam int IdleLimit   = 5000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;

  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   idle_cycles = 0;
  int   random_sent;
  bit   hold_request;

  ulf_req_if req_ch ();
  ulf_res_if res_ch ();

  always #4 clk_i = ~clk_i;

  uart_line_framer_trim #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  ulf_line_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_ch),
    .res           (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ByteW-1:0] pick_line_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(8'h20, 8'h7e));
    if (r < 72) return CH_CR;
    if (r < 78) return CH_LF;
    if (r < 86) return CH_NUL;
    return 8'($urandom());
  endfunction

  task automatic put_req(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.rx_byte <= data;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (mode != MODE_SPARE) random_sent++;
  endtask

  // bytes of one line, an optional end of line, then usually a take
  task automatic send_line(input int force_len);
    int               len;
    int               pick;
    logic [ByteW-1:0] ch;
    if (force_len > 0) begin
      len = force_len;
    end else begin
      pick = $urandom_range(0, 99);
      len  = (pick < 75) ? $urandom_range(1, 12) :
             (pick < 90) ? $urandom_range(13, 50) : $urandom_range(55, 70);
    end
    for (int i = 0; i < len; i++) begin
      ch = (force_len > 0) ? 8'($urandom_range(8'h20, 8'h7e)) : pick_line_char();
      put_req(MODE_BYTE, ch);
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) put_req(MODE_BYTE, CH_LF);
    else if (pick < 9) put_req(MODE_IDLE, 8'($urandom()));
    if ($urandom_range(0, 9) != 0) put_req(MODE_TAKE, 8'($urandom()));
  endtask

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if ($urandom_range(0, 99) < 60) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    bit second_hold_done;
    second_hold_done = 1'b0;
    hold_request     = 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.mode    <= MODE_BYTE;
    req_ch.rx_byte <= '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // take and idle on an empty store, spare mode
    put_req(MODE_TAKE, 8'h00);
    put_req(MODE_IDLE, 8'hff);
    put_req(MODE_SPARE, 8'ha5);
    // line of only cr lf, byte dropped while line is complete
    put_req(MODE_BYTE, CH_CR);
    put_req(MODE_BYTE, CH_LF);
    put_req(MODE_BYTE, 8'h41);
    put_req(MODE_TAKE, 8'h00);
    // leading cr stripped, output stops at interior nul, line closed by idle
    put_req(MODE_BYTE, CH_CR);
    put_req(MODE_BYTE, 8'hff);
    put_req(MODE_BYTE, CH_NUL);
    put_req(MODE_BYTE, 8'h80);
    put_req(MODE_BYTE, 8'h01);
    put_req(MODE_IDLE, 8'h00);
    put_req(MODE_TAKE, 8'hff);
    // trailing nul, cr and lf stripped
    put_req(MODE_BYTE, 8'h7f);
    put_req(MODE_BYTE, CH_NUL);
    put_req(MODE_BYTE, CH_CR);
    put_req(MODE_BYTE, CH_LF);
    put_req(MODE_TAKE, 8'h00);
    // nul at the start leaves an empty line
    put_req(MODE_BYTE, CH_NUL);
    put_req(MODE_BYTE, 8'h41);
    put_req(MODE_IDLE, 8'h00);
    put_req(MODE_TAKE, 8'h00);

    random_sent  = 0;
    hold_request = 1'b1;
    send_line(70);
    while (random_sent < RandomItems) begin
      if (!second_hold_done && random_sent >= 240) begin
        second_hold_done = 1'b1;
        hold_request     = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) send_line(0);
      else put_req(2'($urandom_range(0, 3)), 8'($urandom()));
    end
    req_ch.valid <= 1'b0;

    do @(negedge clk_i); while (pending_count != 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
